// File: rtl/cpid_pkg.sv
package cpid_pkg;

	// Configuration port geometry.
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	// Register indexes on the configuration port.
	localparam logic [CFG_IW-1:0] REG_GAIN_PROP      = 3'd0;
	localparam logic [CFG_IW-1:0] REG_GAIN_INTEG     = 3'd1;
	localparam logic [CFG_IW-1:0] REG_GAIN_DERIV     = 3'd2;
	localparam logic [CFG_IW-1:0] REG_INTEGRAL_LIMIT = 3'd3;
	localparam logic [CFG_IW-1:0] REG_DRIVE_UPPER    = 3'd4;
	localparam logic [CFG_IW-1:0] REG_DRIVE_LOWER    = 3'd5;
	localparam logic [CFG_IW-1:0] REG_FILTER_ON      = 3'd6;

	// Reset values of the registers.
	localparam logic [15:0] RST_INTEGRAL_LIMIT = 16'd1000;
	localparam logic [15:0] RST_DRIVE_UPPER    = 16'd7000;
	localparam logic [15:0] RST_DRIVE_LOWER    = 16'hE4A8;

	// The smoothing filter divides by five.
	localparam logic [3:0] SMOOTH_DIVISOR = 4'd5;

	// Field widths of the streams.
	localparam int VAL_W = 16;
	localparam int DIFF_W = 17;
	localparam int ACC_W = 18;

	typedef struct packed {
		logic signed [15:0] gain_prop;
		logic signed [15:0] gain_integ;
		logic signed [15:0] gain_deriv;
		logic        [15:0] integral_limit;
		logic signed [15:0] drive_upper;
		logic signed [15:0] drive_lower;
		logic               filter_on;
	} cfg_t;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV,
		OP_ERR,
		OP_INTEG,
		OP_CLIP,
		OP_MUL_P,
		OP_MUL_I,
		OP_MUL_D,
		OP_MSUM,
		OP_CLAMP,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		logic   capture;
		dp_op_t op;
	} dp_cmd_t;

endpackage

// File: rtl/cpid_cfg.sv
module cpid_cfg import cpid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wen,
	input  logic [CFG_IW-1:0] windex,
	input  logic [CFG_DW-1:0] wdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	// Register file; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop      <= '0;
			cfg_q.gain_integ     <= '0;
			cfg_q.gain_deriv     <= '0;
			cfg_q.integral_limit <= RST_INTEGRAL_LIMIT;
			cfg_q.drive_upper    <= RST_DRIVE_UPPER;
			cfg_q.drive_lower    <= RST_DRIVE_LOWER;
			cfg_q.filter_on      <= 1'b0;
		end else if (wen) begin
			unique case (windex)
				REG_GAIN_PROP:      cfg_q.gain_prop <= wdata;
				REG_GAIN_INTEG:     cfg_q.gain_integ <= wdata;
				REG_GAIN_DERIV:     cfg_q.gain_deriv <= wdata;
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= wdata;
				REG_DRIVE_UPPER:    cfg_q.drive_upper <= wdata;
				REG_DRIVE_LOWER:    cfg_q.drive_lower <= wdata;
				REG_FILTER_ON:      cfg_q.filter_on <= wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/cpid_dp.sv
module cpid_dp import cpid_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	input  cfg_t                    cfg,
	input  logic signed [VAL_W-1:0] in_measured,
	input  logic signed [VAL_W-1:0] in_setpoint,
	input  logic                    in_clear,
	output logic        [VAL_W-1:0] drive,
	output logic                    clamped
);

	localparam int EW = DIFF_W + FRAC_BITS;
	localparam int DW = EW + 1;
	localparam int NW = EW + 3;
	localparam int PW = 16 + DW;
	localparam int SW = PW + 2;
	localparam logic [EW-1:0] E_BIAS = EW'((64'd1 << FRAC_BITS) - 64'd1);
	localparam logic [SW-1:0] T_BIAS = SW'((64'd1 << (2 * FRAC_BITS)) - 64'd1);
	// Reciprocal of five: with 2^RK one below a multiple of five the rounded-up
	// reciprocal is off by exactly 1/5, so the quotient is exact below 2^RK.
	localparam int RK = (NW - 1) + ((6 - ((NW - 1) % 4)) % 4);
	localparam int RW = RK - 2;
	localparam logic [RW-1:0] RECIP =
		RW'(((64'd1 << RK) + 64'd1) / 64'(SMOOTH_DIVISOR));

	logic signed [DIFF_W-1:0] diff_q;
	logic                     clr_q;
	logic signed [EW-1:0]     raw_q;
	logic        [NW-1:0]     dv_q;
	logic        [EW-1:0]     quo_q;
	logic                     neg_q;
	logic signed [EW-1:0]     e_q;
	logic signed [DW-1:0]     de_q;
	logic signed [EW-1:0]     err_last_q;
	logic signed [ACC_W-1:0]  accum_q;
	logic signed [ACC_W-1:0]  acc_tmp_q;
	logic signed [PW-1:0]     prod_q;
	logic signed [SW-1:0]     sum_q;
	logic                     clamped_q;

	logic signed [EW-1:0]     diff_ext;
	logic signed [EW-1:0]     raw_c;
	logic signed [NW-1:0]     num_c;
	logic        [NW-1:0]     num_mag;
	logic        [NW+RW-1:0]  recip_p;
	logic signed [EW-1:0]     e_div;
	logic signed [EW-1:0]     e_bias;
	logic signed [DIFF_W-1:0] e_int;
	logic signed [ACC_W-1:0]  acc_base;
	logic signed [ACC_W-1:0]  acc_sum;
	logic signed [ACC_W-1:0]  lim_p;
	logic signed [ACC_W-1:0]  lim_n;
	logic signed [15:0]       mul_a;
	logic signed [DW-1:0]     mul_b;
	logic signed [PW-1:0]     mul_p;
	logic signed [SW-1:0]     up_w;
	logic signed [SW-1:0]     lo_w;
	logic signed [SW-1:0]     clip1;
	logic signed [SW-1:0]     clip2;
	logic                     hit1;
	logic                     hit2;
	logic        [SW-1:0]     t_bias;

	// Raw error and the filter numerator 4*old + raw.
	assign diff_ext = EW'(diff_q);
	assign raw_c    = diff_ext <<< FRAC_BITS;
	assign num_c    = (NW'(err_last_q) <<< 2) + NW'(raw_c);
	assign num_mag  = num_c[NW-1] ? NW'(-num_c) : NW'(num_c);

	// Divide by five as a multiply by the reciprocal; the sign is put back after.
	assign recip_p = {{RW{1'b0}}, dv_q} * {{NW{1'b0}}, RECIP};
	assign e_div   = neg_q ? -$signed(quo_q) : $signed(quo_q);

	// Integer part of the error, truncated toward zero, added to the integral.
	assign e_bias   = e_q + (e_q[EW-1] ? $signed(E_BIAS) : $signed(EW'(0)));
	assign e_int    = e_bias[EW-1:FRAC_BITS];
	assign acc_base = clr_q ? '0 : accum_q;
	assign acc_sum  = acc_base + ACC_W'(e_int);
	assign lim_p    = $signed({2'b00, cfg.integral_limit});
	assign lim_n    = -lim_p;

	// Shared multiplier operand selection.
	always_comb begin
		unique case (cmd.op)
			OP_MUL_I: begin
				mul_a = cfg.gain_integ;
				mul_b = DW'(accum_q);
			end
			OP_MUL_D: begin
				mul_a = cfg.gain_deriv;
				mul_b = de_q;
			end
			default: begin
				mul_a = cfg.gain_prop;
				mul_b = DW'(e_q);
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Output limits: upper first, then lower, which wins when they cross.
	assign up_w  = SW'($signed(cfg.drive_upper)) <<< (2 * FRAC_BITS);
	assign lo_w  = SW'($signed(cfg.drive_lower)) <<< (2 * FRAC_BITS);
	assign hit1  = (sum_q > up_w);
	assign clip1 = hit1 ? up_w : sum_q;
	assign hit2  = (clip1 < lo_w);
	assign clip2 = hit2 ? lo_w : clip1;

	// Truncation toward zero of the fixed-point drive.
	assign t_bias = sum_q + (sum_q[SW-1] ? T_BIAS : SW'(0));

	// Persistent controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_last_q <= '0;
			accum_q    <= '0;
		end else begin
			if (cmd.op == OP_INTEG) begin
				err_last_q <= e_q;
			end
			if (cmd.op == OP_CLIP) begin
				if (acc_tmp_q > lim_p) begin
					accum_q <= lim_p;
				end else if (acc_tmp_q < lim_n) begin
					accum_q <= lim_n;
				end else begin
					accum_q <= acc_tmp_q;
				end
			end
		end
	end

	// Working registers of one step.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			diff_q <= DIFF_W'(in_setpoint) - DIFF_W'(in_measured);
			clr_q  <= in_clear;
		end
		unique case (cmd.op)
			OP_LOAD: begin
				raw_q <= raw_c;
				dv_q  <= num_mag;
				neg_q <= num_c[NW-1];
			end
			OP_DIV: begin
				quo_q <= recip_p[RK+EW-1:RK];
			end
			OP_ERR: begin
				e_q <= cfg.filter_on ? e_div : raw_q;
			end
			OP_INTEG: begin
				de_q      <= cfg.filter_on ? (DW'(e_q) - DW'(raw_q))
				                           : (DW'(e_q) - DW'(err_last_q));
				acc_tmp_q <= acc_sum;
			end
			OP_MUL_P: begin
				prod_q <= mul_p;
			end
			OP_MUL_I: begin
				sum_q  <= SW'(prod_q);
				prod_q <= mul_p;
			end
			OP_MUL_D: begin
				sum_q  <= sum_q + (SW'(prod_q) <<< FRAC_BITS);
				prod_q <= mul_p;
			end
			OP_MSUM: begin
				sum_q <= sum_q + SW'(prod_q);
			end
			OP_CLAMP: begin
				sum_q <= clip2;
				clamped_q <= hit1 | hit2;
			end
			default: begin
			end
		endcase
	end

	// The result word is held until the controller loads the next one.
	logic [VAL_W-1:0] drive_out_q;
	logic             clamped_out_q;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			drive_out_q   <= t_bias[2*FRAC_BITS+VAL_W-1:2*FRAC_BITS];
			clamped_out_q <= clamped_q;
		end
	end

	assign drive   = drive_out_q;
	assign clamped = clamped_out_q;

endmodule

// File: rtl/cpid_ctrl.sv
module cpid_ctrl import cpid_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  logic    filter_on,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_ERR,
		ST_INTEG,
		ST_CLIP,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_MSUM,
		ST_CLAMP,
		ST_OUT
	} state_t;

	state_t        state_q;
	logic          out_valid_q;
	logic          out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// Step sequencer and output word flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD:  state_q <= filter_on ? ST_DIV : ST_ERR;
				ST_DIV:   state_q <= ST_ERR;
				ST_ERR:   state_q <= ST_INTEG;
				ST_INTEG: state_q <= ST_CLIP;
				ST_CLIP:  state_q <= ST_MUL_P;
				ST_MUL_P: state_q <= ST_MUL_I;
				ST_MUL_I: state_q <= ST_MUL_D;
				ST_MUL_D: state_q <= ST_MSUM;
				ST_MSUM:  state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// Datapath command decode.
	always_comb begin
		cmd.capture = in_valid && in_ready;
		unique case (state_q)
			ST_LOAD:  cmd.op = OP_LOAD;
			ST_DIV:   cmd.op = OP_DIV;
			ST_ERR:   cmd.op = OP_ERR;
			ST_INTEG: cmd.op = OP_INTEG;
			ST_CLIP:  cmd.op = OP_CLIP;
			ST_MUL_P: cmd.op = OP_MUL_P;
			ST_MUL_I: cmd.op = OP_MUL_I;
			ST_MUL_D: cmd.op = OP_MUL_D;
			ST_MSUM:  cmd.op = OP_MSUM;
			ST_CLAMP: cmd.op = OP_CLAMP;
			ST_OUT:   cmd.op = out_free ? OP_OUT : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

endmodule

// File: rtl/clamped_pid_controller.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata measured, setpoint; tuser clear_accum
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata drive; tuser clamped
// cfg       in         cfg_wen (no wait)              cfg_windex, cfg_wdata
//
// A new item is accepted only from idle, after the last one has left the final step; with the
// filter on a divide step is added. The sequenced steps hold one reciprocal multiply for the
// divide by five and three passes through one shared multiplier.
// Reset clears the integral, the last error, the registers to their defaults and the flow.
// While a result word waits on m_axis the next word is accepted and worked on; it waits
// in the last step until the output register is free.
module clamped_pid_controller import cpid_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [CFG_IW-1:0] cfg_windex,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// measured [15:0], setpoint [31:16]
	input  logic [31:0]       s_axis_tdata,
	// clear_accum [0]
	input  logic [0:0]        s_axis_tuser,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// drive [15:0]
	output logic [15:0]       m_axis_tdata,
	// clamped [0]
	output logic [0:0]        m_axis_tuser
);

	cfg_t    cfg;
	dp_cmd_t cmd;

	cpid_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wen    (cfg_wen),
		.windex (cfg_windex),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	cpid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.filter_on (cfg.filter_on),
		.cmd       (cmd)
	);

	cpid_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg),
		.in_measured (s_axis_tdata[15:0]),
		.in_setpoint (s_axis_tdata[31:16]),
		.in_clear    (s_axis_tuser[0]),
		.drive       (m_axis_tdata),
		.clamped     (m_axis_tuser[0])
	);

`ifndef SYNTHESIS
	// An accepted word closes the input until its step is done.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
	else $error("input accepted while a step was in progress");

	// A result word appears only at the end of a step, never straight from idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
	else $error("result word raised without a finished step");

	// The datapath loads the result register only when the output side is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |-> (!m_axis_tvalid || m_axis_tready))
	else $error("result register overwritten while a word was waiting");
`endif

endmodule
